FILE: sv/hrs_pkg.sv
`default_nettype none

package hrs_pkg;

    // configuration and field widths
    localparam int CNT_W      = 11;
    localparam int HOLD_W     = 8;
    localparam int IDX_OUT_W  = 10;
    localparam int SEG_W      = 7;
    localparam int DCNT_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int SEG_POS    = 4;

    localparam int DEF_MAX_ITEMS  = 1024;
    localparam int DEF_MAX_DIGITS = 4;

    localparam logic [CNT_W-1:0]  RST_ITEM_COUNT = CNT_W'(1);
    localparam logic [HOLD_W-1:0] RST_HOLD_TICKS = HOLD_W'(15);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = CFG_IDX_W'(1);

    // divide by ten as multiply by 6554 / 2^16, exact below 16384
    localparam int DEC_BASE  = 10;
    localparam int RECIP     = 6554;
    localparam int RECIP_SH  = 16;
    localparam int RECIP_MAX = 16384;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_DIGIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              armed;
        logic [HOLD_W-1:0] ticks;
        logic              fire;
    } trk_t;

    // segments a..g in bits 0..6
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = '0;
        endcase
        return s;
    endfunction

    // edge and hold tracking of one button
    function automatic trk_t track(input logic armed, input logic [HOLD_W-1:0] ticks,
                                   input logic pressed, input logic level,
                                   input logic alone, input logic [HOLD_W-1:0] hold);
        trk_t              r;
        logic [HOLD_W-1:0] inc;
        r.armed = armed;
        r.ticks = ticks;
        r.fire  = 1'b0;
        inc     = ticks + HOLD_W'(1);
        if (!armed)
        begin
            if (pressed)
            begin
                r.armed = 1'b1;
                r.ticks = '0;
            end
        end
        else if (level)
        begin
            if (alone)
            begin
                if (inc >= hold)
                begin
                    r.ticks = '0;
                    r.fire  = 1'b1;
                end
                else
                begin
                    r.ticks = inc;
                end
            end
        end
        else
        begin
            r.armed = 1'b0;
            r.fire  = (ticks != '0);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/hrs_div10.sv
`default_nettype none

module hrs_div10 #(
    parameter int W = 10
) (
    input  wire logic [W-1:0]             num,
    output logic      [W-1:0]             quo,
    output logic      [hrs_pkg::SEG_W-1:0] seg
);
    import hrs_pkg::*;

    localparam int PW = W + RECIP_SH;

    logic [PW-1:0] prod;
    logic [W+3:0]  q10;
    logic [W+3:0]  rem_full;
    logic [3:0]    rem;

    assign prod     = PW'(num) * PW'(RECIP);
    assign quo      = prod[RECIP_SH +: W];
    assign q10      = ((W+4)'(quo) << 3) + ((W+4)'(quo) << 1);
    assign rem_full = (W+4)'(num) - q10;
    assign rem      = rem_full[3:0];
    assign seg      = seg_of(rem);

endmodule

`default_nettype wire

FILE: sv/hold_repeat_selector_seven_segment_core.sv
// Up/down item selector with hold auto-repeat and a four digit seven-segment readout.
//
// in channel: one word per frame tick (player_present and the down/up pressed, level
// and alone bits), valid/ready. out channel: one word per input word with the
// selection, the sticky fault and the digit segments, valid/ready.
// cfg channel: cfg_index 0 writes item_count, 1 writes hold_ticks; always ready. The user
// must write it only while the block is idle; the block itself does not enforce this.
//
// Each word passes from acceptance to the result register through the button tracking
// and index step, the decimal digits one at a time in the shared divide-by-ten unit
// (none when there is no selection or the fault is set, up to MAX_DIGITS), and the
// output load; the sequencer idles again only after the load, so no new word is taken
// before then. in_ready is high only while the sequencer idles; a finished result
// waits in the output register, so the next word can be taken while the receiver
// stalls; that word then holds in the sequencer until the output register frees up.
//
// Reset clears the selection, the button tracking and the fault; item_count returns
// to 1 and hold_ticks to 15. No result is pending after reset.
`default_nettype none

module hold_repeat_selector_seven_segment_core #(
    parameter int MAX_ITEMS  = hrs_pkg::DEF_MAX_ITEMS,
    parameter int MAX_DIGITS = hrs_pkg::DEF_MAX_DIGITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [hrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hrs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             player_present,
    input  wire logic                             down_pressed,
    input  wire logic                             down_level,
    input  wire logic                             down_alone,
    input  wire logic                             up_pressed,
    input  wire logic                             up_level,
    input  wire logic                             up_alone,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  sel_valid,
    output logic      [hrs_pkg::IDX_OUT_W-1:0]    sel_index,
    output logic                                  sel_changed,
    output logic                                  fault,
    output logic      [hrs_pkg::DCNT_W-1:0]       digit_count,
    output logic      [hrs_pkg::SEG_W-1:0]        seg_ones,
    output logic      [hrs_pkg::SEG_W-1:0]        seg_tens,
    output logic      [hrs_pkg::SEG_W-1:0]        seg_hundreds,
    output logic      [hrs_pkg::SEG_W-1:0]        seg_thousands
);
    import hrs_pkg::*;

    // item_count cannot exceed its 11 bit field
    localparam int NCAP = (MAX_ITEMS < (1 << CNT_W) - 1) ? MAX_ITEMS : (1 << CNT_W) - 1;
    localparam int IW   = $clog2(NCAP);

    // configuration
    logic [CNT_W-1:0]  item_count_reg;
    logic [HOLD_W-1:0] hold_ticks_reg;

    // captured input word
    logic player_reg, dp_reg, dl_reg, da_reg, upp_reg, ul_reg, ua_reg;

    // selector state
    logic              has_sel_reg;
    logic [IW-1:0]     cur_reg;
    logic              down_armed_reg, up_armed_reg;
    logic [HOLD_W-1:0] down_ticks_reg, up_ticks_reg;
    logic              halted_reg;
    logic              changed_reg;

    // digit sequencer
    state_t            state_reg, state_next;
    logic [IW-1:0]     t_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DCNT_W-1:0] ndig_reg;
    logic [SEG_W-1:0]  seg_reg [SEG_POS];

    // output register
    logic                 out_valid_reg;
    logic                 o_sel_valid_reg, o_changed_reg, o_fault_reg;
    logic [IDX_OUT_W-1:0] o_index_reg;
    logic [DCNT_W-1:0]    o_ndig_reg;
    logic [SEG_W-1:0]     o_seg_reg [SEG_POS];

    // step logic
    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  cur_ext;
    logic [CNT_W-1:0]  cur_inc;
    logic              step_halted;
    trk_t              trk_d, trk_u;
    logic              step_has, step_changed;
    logic [IW-1:0]     step_cur;
    logic              step_down_armed, step_up_armed;
    logic [HOLD_W-1:0] step_down_ticks, step_up_ticks;

    // shared divide unit
    logic [IW-1:0]    div_q;
    logic [SEG_W-1:0] div_seg;
    logic             dig_last;
    logic             dig_full;

    // sequencer controls
    logic do_step, do_digit, do_load, can_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg <= RST_ITEM_COUNT;
            hold_ticks_reg <= RST_HOLD_TICKS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ITEM_COUNT: item_count_reg <= cfg_data;
                REG_HOLD_TICKS: hold_ticks_reg <= cfg_data[HOLD_W-1:0];
                default:        ;
            endcase
        end
    end

    // one tick of button tracking and index stepping
    always_comb
    begin
        n = (item_count_reg > CNT_W'(NCAP)) ? CNT_W'(NCAP) : item_count_reg;
        cur_ext = CNT_W'(cur_reg);
        cur_inc = cur_ext + CNT_W'(1);
        step_halted = halted_reg || (n == '0) || (has_sel_reg && (cur_ext >= n));

        trk_d = track(down_armed_reg, down_ticks_reg, dp_reg, dl_reg, da_reg,
                      hold_ticks_reg);
        trk_u = track(up_armed_reg, up_ticks_reg, upp_reg, ul_reg, ua_reg,
                      hold_ticks_reg);

        step_has        = has_sel_reg;
        step_cur        = cur_reg;
        step_changed    = 1'b0;
        step_down_armed = down_armed_reg;
        step_down_ticks = down_ticks_reg;
        step_up_armed   = up_armed_reg;
        step_up_ticks   = up_ticks_reg;

        if (!step_halted && player_reg)
        begin
            step_down_armed = trk_d.armed;
            step_down_ticks = trk_d.ticks;
            if (trk_d.fire)
            begin
                if (!has_sel_reg || (cur_inc == n))
                    step_cur = '0;
                else
                    step_cur = IW'(cur_inc);
                step_has     = 1'b1;
                step_changed = 1'b1;
            end
            else
            begin
                // up only looked at when down did not fire
                step_up_armed = trk_u.armed;
                step_up_ticks = trk_u.ticks;
                if (trk_u.fire)
                begin
                    if (has_sel_reg)
                        step_cur = (cur_reg == '0) ? IW'(n - CNT_W'(1)) : cur_reg - IW'(1);
                    else
                        step_cur = (n >= CNT_W'(2)) ? IW'(n - CNT_W'(2)) : '0;
                    step_has     = 1'b1;
                    step_changed = 1'b1;
                end
            end
        end
    end

    hrs_div10 #(
        .W (IW)
    ) u_div10 (
        .num (t_reg),
        .quo (div_q),
        .seg (div_seg)
    );

    assign dig_last = (div_q == '0);
    assign dig_full = ((cnt_reg + DCNT_W'(1)) == DCNT_W'(MAX_DIGITS));
    assign can_load = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                if (!step_halted && step_has)
                    state_next = S_DIGIT;
                else
                    state_next = S_DONE;
            end
            S_DIGIT:
            begin
                if (dig_last || dig_full)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (can_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        do_step  = 1'b0;
        do_digit = 1'b0;
        do_load  = 1'b0;
        case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            S_STEP:  do_step  = 1'b1;
            S_DIGIT: do_digit = 1'b1;
            S_DONE:  do_load  = can_load;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            player_reg <= player_present;
            dp_reg     <= down_pressed;
            dl_reg     <= down_level;
            da_reg     <= down_alone;
            upp_reg    <= up_pressed;
            ul_reg     <= up_level;
            ua_reg     <= up_alone;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_sel_reg    <= 1'b0;
            cur_reg        <= '0;
            down_armed_reg <= 1'b0;
            up_armed_reg   <= 1'b0;
            down_ticks_reg <= '0;
            up_ticks_reg   <= '0;
            halted_reg     <= 1'b0;
            changed_reg    <= 1'b0;
        end
        else if (do_step)
        begin
            has_sel_reg    <= step_has;
            cur_reg        <= step_cur;
            down_armed_reg <= step_down_armed;
            up_armed_reg   <= step_up_armed;
            down_ticks_reg <= step_down_ticks;
            up_ticks_reg   <= step_up_ticks;
            halted_reg     <= step_halted;
            changed_reg    <= step_changed;
        end
    end

    // one decimal digit per cycle, least significant first
    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            t_reg    <= step_cur;
            cnt_reg  <= '0;
            ndig_reg <= '0;
            for (int i = 0; i < SEG_POS; i++)
                seg_reg[i] <= '0;
        end
        else if (do_digit)
        begin
            t_reg   <= div_q;
            cnt_reg <= cnt_reg + DCNT_W'(1);
            if (dig_last)
            begin
                seg_reg[cnt_reg[1:0]] <= div_seg;
                ndig_reg              <= cnt_reg + DCNT_W'(1);
            end
            else if (dig_full)
            begin
                // too many digits, blank readout
                for (int i = 0; i < SEG_POS; i++)
                    seg_reg[i] <= '0;
                ndig_reg <= '0;
            end
            else
            begin
                seg_reg[cnt_reg[1:0]] <= div_seg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (do_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            o_sel_valid_reg <= has_sel_reg;
            o_index_reg     <= has_sel_reg ? IDX_OUT_W'(cur_reg) : '0;
            o_changed_reg   <= changed_reg;
            o_fault_reg     <= halted_reg;
            o_ndig_reg      <= ndig_reg;
            for (int i = 0; i < SEG_POS; i++)
                o_seg_reg[i] <= seg_reg[i];
        end
    end

    assign out_valid     = out_valid_reg;
    assign sel_valid     = o_sel_valid_reg;
    assign sel_index     = o_index_reg;
    assign sel_changed   = o_changed_reg;
    assign fault         = o_fault_reg;
    assign digit_count   = o_ndig_reg;
    assign seg_ones      = o_seg_reg[0];
    assign seg_tens      = o_seg_reg[1];
    assign seg_hundreds  = o_seg_reg[2];
    assign seg_thousands = o_seg_reg[3];

    // fault never clears once raised
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared");

    // a faulted word carries a blank readout and no step
    a_fault_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fault) |-> (digit_count == '0 && !sel_changed))
        else $error("faulted word not blank");

    // digit counter stays within the readout
    a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIGIT) |-> (cnt_reg < DCNT_W'(MAX_DIGITS)))
        else $error("digit counter overran");

    // no selection means no digits shown
    a_nosel_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !sel_valid) |-> (digit_count == '0 && sel_index == '0))
        else $error("readout without selection");

endmodule

`default_nettype wire

FILE: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hrs_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int DRAIN_CYCLES   = 12;
    localparam int PRESSURE_AT    = 700;
    localparam int NUM_PHASES     = 6;

    // button word: player present, then down edge/level/alone, then up edge/level/alone
    typedef struct packed {
        logic present;
        logic dn_p;
        logic dn_l;
        logic dn_a;
        logic up_p;
        logic up_l;
        logic up_a;
    } stim_t;

    typedef struct packed {
        logic                 valid;
        logic [IDX_OUT_W-1:0] index;
        logic                 changed;
        logic                 fault;
        logic [DCNT_W-1:0]    ndig;
        logic [SEG_W-1:0]     ones;
        logic [SEG_W-1:0]     tens;
        logic [SEG_W-1:0]     hund;
        logic [SEG_W-1:0]     thou;
    } readout_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        stim_t                 stim;
        logic                  typed;
        readout_t              want;
    } row_t;

    localparam readout_t BLANK = '0;

    localparam logic [SEG_W-1:0] DIGIT_SEGS [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    localparam row_t SCRIPT [28] = '{
        // nothing selected yet, count 1
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_000_000, 1'b1, BLANK},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b0_111_111, 1'b1, BLANK},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_111_000, 1'b1, BLANK},
        // tap released with no hold tick does not step
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_000_000, 1'b1, BLANK},
        '{ROW_REG,  REG_ITEM_COUNT, 11'd1024, 7'b0, 1'b0, BLANK},
        '{ROW_REG,  REG_HOLD_TICKS, 11'd1, 7'b0, 1'b0, BLANK},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_000_111, 1'b1, BLANK},
        // first up lands two below the count
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_000_011, 1'b1,
          '{1'b1, 10'd1022, 1'b1, 1'b0, 3'd4, 7'h5B, 7'h5B, 7'h3F, 7'h06}},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_110_010, 1'b0, BLANK},
        // both fire-ready: down wins, up untouched
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_011_011, 1'b0, BLANK},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_011_000, 1'b1,
          '{1'b1, 10'd0, 1'b1, 1'b0, 3'd1, 7'h3F, 7'h00, 7'h00, 7'h00}},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_000_011, 1'b1,
          '{1'b1, 10'd1023, 1'b1, 1'b0, 3'd4, 7'h4F, 7'h5B, 7'h3F, 7'h06}},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_000_000, 1'b0, BLANK},
        // oversized count behaves as the maximum
        '{ROW_REG,  REG_HOLD_TICKS, 11'd255, 7'b0, 1'b0, BLANK},
        '{ROW_REG,  REG_ITEM_COUNT, 11'd2047, 7'b0, 1'b0, BLANK},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_111_000, 1'b0, BLANK},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_011_000, 1'b0, BLANK},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_000_000, 1'b0, BLANK},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_000_111, 1'b0, BLANK},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_000_011, 1'b0, BLANK},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_000_010, 1'b0, BLANK},
        // player absent freezes the release
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b0_000_000, 1'b0, BLANK},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_000_000, 1'b0, BLANK},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_111_000, 1'b0, BLANK},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_011_000, 1'b0, BLANK},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_000_000, 1'b0, BLANK},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_111_111, 1'b0, BLANK},
        '{ROW_ITEM, REG_ITEM_COUNT, 11'd0, 7'b1_100_100, 1'b0, BLANK}
    };

    // counts only ever rise, so the index never falls out of range before the fault phase
    localparam int PHASE_COUNT [NUM_PHASES] = '{1, 2, 10, 137, 1024, 2047};
    localparam int PHASE_HOLD  [NUM_PHASES] = '{2, 1, 4, 9, 255, 6};
    localparam int PHASE_WORDS [NUM_PHASES] = '{120, 180, 180, 180, 200, 180};

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  in_valid       = 1'b0;
    logic                  in_ready;
    logic                  player_present = 1'b0;
    logic                  down_pressed   = 1'b0;
    logic                  down_level     = 1'b0;
    logic                  down_alone     = 1'b0;
    logic                  up_pressed     = 1'b0;
    logic                  up_level       = 1'b0;
    logic                  up_alone       = 1'b0;
    logic                  out_valid;
    logic                  out_ready      = 1'b0;
    logic                  sel_valid;
    logic [IDX_OUT_W-1:0]  sel_index;
    logic                  sel_changed;
    logic                  fault;
    logic [DCNT_W-1:0]     digit_count;
    logic [SEG_W-1:0]      seg_ones;
    logic [SEG_W-1:0]      seg_tens;
    logic [SEG_W-1:0]      seg_hundreds;
    logic [SEG_W-1:0]      seg_thousands;

    // predicted selector state
    logic [CNT_W-1:0]  pr_count   = RST_ITEM_COUNT;
    logic [HOLD_W-1:0] pr_hold    = RST_HOLD_TICKS;
    logic              pr_has_sel = 1'b0;
    int                pr_item    = 0;
    logic              dn_armed   = 1'b0;
    logic              up_armed   = 1'b0;
    logic [HOLD_W-1:0] dn_ticks   = '0;
    logic [HOLD_W-1:0] up_ticks   = '0;
    logic              pr_halted  = 1'b0;

    readout_t pending_readouts [$];
    int       words_sent   = 0;
    int       mismatches   = 0;
    int       quiet_cycles = 0;
    int       snd_idle     = 0;
    int       rcv_idle     = 0;
    bit       drained      = 1'b0;

    hold_repeat_selector_seven_segment_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .player_present (player_present),
        .down_pressed   (down_pressed),
        .down_level     (down_level),
        .down_alone     (down_alone),
        .up_pressed     (up_pressed),
        .up_level       (up_level),
        .up_alone       (up_alone),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sel_valid      (sel_valid),
        .sel_index      (sel_index),
        .sel_changed    (sel_changed),
        .fault          (fault),
        .digit_count    (digit_count),
        .seg_ones       (seg_ones),
        .seg_tens       (seg_tens),
        .seg_hundreds   (seg_hundreds),
        .seg_thousands  (seg_thousands)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic advance_button(inout logic armed, inout logic [HOLD_W-1:0] ticks,
                                  input logic p, input logic l, input logic a,
                                  output logic fire);
        fire = 1'b0;
        if (!armed)
        begin
            if (p)
            begin
                armed = 1'b1;
                ticks = '0;
            end
        end
        else if (l)
        begin
            if (a)
            begin
                ticks = ticks + 1'b1;
                if (ticks >= pr_hold)
                begin
                    ticks = '0;
                    fire  = 1'b1;
                end
            end
        end
        else
        begin
            armed = 1'b0;
            fire  = (ticks != '0);
        end
    endtask

    task automatic advance_selector(input stim_t w, output readout_t r);
        int               n;
        int               t;
        int               nd;
        int               k;
        logic             fire_dn;
        logic             fire_up;
        logic [SEG_W-1:0] segs [4];
        n       = (pr_count > DEF_MAX_ITEMS) ? DEF_MAX_ITEMS : int'(pr_count);
        r       = '0;
        fire_up = 1'b0;
        for (k = 0; k < 4; k++)
            segs[k] = '0;
        if (!pr_halted && (n < 1 || (pr_has_sel && pr_item >= n)))
            pr_halted = 1'b1;
        if (!pr_halted && w.present)
        begin
            advance_button(dn_armed, dn_ticks, w.dn_p, w.dn_l, w.dn_a, fire_dn);
            // up is skipped whenever down steps
            if (!fire_dn)
                advance_button(up_armed, up_ticks, w.up_p, w.up_l, w.up_a, fire_up);
            if (fire_dn)
                pr_item = pr_has_sel ? (pr_item + 1) % n : 0;
            else if (fire_up && pr_has_sel)
                pr_item = (pr_item == 0) ? n - 1 : pr_item - 1;
            else if (fire_up)
                pr_item = (n >= 2) ? n - 2 : 0;
            if (fire_dn || fire_up)
            begin
                pr_has_sel = 1'b1;
                r.changed  = 1'b1;
            end
        end
        nd = 0;
        if (!pr_halted && pr_has_sel)
        begin
            t = pr_item;
            do
            begin
                nd++;
                t = t / 10;
            end
            while (t != 0);
            if (nd > DEF_MAX_DIGITS)
                nd = 0;
            t = pr_item;
            for (k = 0; k < nd; k++)
            begin
                segs[k] = DIGIT_SEGS[t % 10];
                t = t / 10;
            end
        end
        r.valid = pr_has_sel;
        r.index = pr_has_sel ? IDX_OUT_W'(pr_item) : '0;
        r.fault = pr_halted;
        r.ndig  = DCNT_W'(nd);
        r.ones  = segs[0];
        r.tens  = segs[1];
        r.hund  = segs[2];
        r.thou  = segs[3];
    endtask

    function automatic void compare_field(input string what, input int got, input int want);
        if (got != want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    task automatic check_readout(input readout_t got);
        readout_t want;
        if (pending_readouts.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result word with nothing pending", $time);
        end
        else
        begin
            want = pending_readouts.pop_front();
            compare_field("sel_valid", got.valid, want.valid);
            compare_field("sel_index", got.index, want.index);
            compare_field("sel_changed", got.changed, want.changed);
            compare_field("fault", got.fault, want.fault);
            compare_field("digit_count", got.ndig, want.ndig);
            compare_field("seg_ones", got.ones, want.ones);
            compare_field("seg_tens", got.tens, want.tens);
            compare_field("seg_hundreds", got.hund, want.hund);
            compare_field("seg_thousands", got.thou, want.thou);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_readout('{sel_valid, sel_index, sel_changed, fault, digit_count,
                            seg_ones, seg_tens, seg_hundreds, seg_thousands});
        out_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_word(input stim_t w, input bit typed, input readout_t want);
        readout_t predicted;
        if (words_sent < 430)
        begin
            snd_idle = 11;
            rcv_idle = 86;
        end
        else if (words_sent < 860)
        begin
            snd_idle = 86;
            rcv_idle = 11;
        end
        else
        begin
            snd_idle = 0;
            rcv_idle = 0;
        end
        while ($urandom_range(0, 99) < snd_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        {player_present, down_pressed, down_level, down_alone,
         up_pressed, up_level, up_alone} <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_selector(w, predicted);
        pending_readouts.push_back(typed ? want : predicted);
        words_sent++;
    endtask

    // registers only change once the pipeline has emptied
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (pending_readouts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_ITEM_COUNT)
            pr_count = val;
        else if (idx == REG_HOLD_TICKS)
            pr_hold = val[HOLD_W-1:0];
    endtask

    function automatic stim_t button_word(input bit on_down, input logic p, input logic l,
                                          input logic a);
        stim_t w;
        w         = '0;
        w.present = 1'b1;
        if (on_down)
            {w.dn_p, w.dn_l, w.dn_a} = {p, l, a};
        else
            {w.up_p, w.up_l, w.up_a} = {p, l, a};
        // the other button now and then joins in
        if ($urandom_range(0, 15) == 0)
        begin
            if (on_down)
                {w.up_p, w.up_l} = 2'b11;
            else
                {w.dn_p, w.dn_l} = 2'b11;
        end
        return w;
    endfunction

    task automatic gesture(input bit on_down, input int held);
        stim_t w;
        int    k;
        send_word(button_word(on_down, 1'b1, 1'b1, 1'b1), 1'b0, BLANK);
        for (k = 0; k < held; k++)
        begin
            w = button_word(on_down, $urandom_range(0, 7) == 0, 1'b1,
                            $urandom_range(0, 7) != 0);
            if ($urandom_range(0, 15) == 0)
                w.present = 1'b0;
            send_word(w, 1'b0, BLANK);
        end
        send_word(button_word(on_down, 1'b0, 1'b0, 1'b0), 1'b0, BLANK);
    endtask

    task automatic run_phase(input int budget);
        int    first;
        int    held;
        stim_t noise;
        first = words_sent;
        while (words_sent - first < budget)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    noise         = 7'($urandom_range(0, 127));
                    noise.present = ($urandom_range(0, 3) != 0);
                    send_word(noise, 1'b0, BLANK);
                end
            end
            else
            begin
                // the first gesture of a phase, if no noise comes first, is held for at least the hold ticks
                if (words_sent == first || $urandom_range(0, 7) == 0)
                    held = pr_hold * $urandom_range(1, 2) + $urandom_range(0, 2);
                else
                    held = $urandom_range(0, 4);
                gesture(1'($urandom_range(0, 1)), held);
            end
            if (!drained && words_sent >= PRESSURE_AT)
            begin
                drained = 1'b1;
                in_valid <= 1'b0;
                while (pending_readouts.size() != 0)
                    @(posedge clk);
            end
        end
    endtask

    initial
    begin
        int i;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < $size(SCRIPT); i++)
        begin
            if (SCRIPT[i].kind == ROW_REG)
                write_reg(SCRIPT[i].reg_idx, SCRIPT[i].reg_val);
            else
                send_word(SCRIPT[i].stim, SCRIPT[i].typed, SCRIPT[i].want);
        end

        for (i = 0; i < NUM_PHASES; i++)
        begin
            write_reg(REG_ITEM_COUNT, CFG_DATA_W'(PHASE_COUNT[i]));
            write_reg(REG_HOLD_TICKS, CFG_DATA_W'(PHASE_HOLD[i]));
            run_phase(PHASE_WORDS[i]);
        end

        // shrink the count to the index (or to zero) and run on with the fault latched
        write_reg(REG_ITEM_COUNT,
                  (pr_has_sel && pr_item != 0) ? CFG_DATA_W'(pr_item) : '0);
        run_phase(40);

        in_valid <= 1'b0;
        while (pending_readouts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/hrs_pkg.sv
sv/hrs_div10.sv
sv/hold_repeat_selector_seven_segment_core.sv
sim/tb.sv
